FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the option pricer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define BOP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BOP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/bop_pkg.sv
// Package of the option pricer: widths, codes, control and factor structs and payoff function.
package bop_pkg;

  localparam int VAL_W         = 48;
  localparam int FAC_W         = 32;
  localparam int STEP_W        = 9;
  localparam int CFG_IDX_W     = 3;
  localparam int MAX_STEPS_DEF = 256;
  localparam int PH_W          = 3;

  localparam logic [FAC_W-1:0] ONE_Q31 = 32'h8000_0000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_PROB       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DISCOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 3'd4;

  // Register reset values.
  localparam logic [FAC_W-1:0]  RST_UP_FACTOR     = 32'h4000_0000;
  localparam logic [FAC_W-1:0]  RST_DOWN_FACTOR   = 32'h4000_0000;
  localparam logic [FAC_W-1:0]  RST_UP_PROB       = 32'h4000_0000;
  localparam logic [FAC_W-1:0]  RST_STEP_DISCOUNT = 32'h8000_0000;
  localparam logic [STEP_W-1:0] RST_STEP_COUNT    = 9'd64;

  // Phases within one lattice level.
  localparam logic [PH_W-1:0] PH_FWD_COMMIT = 3'd2;
  localparam logic [PH_W-1:0] PH_BWD_A      = 3'd0;
  localparam logic [PH_W-1:0] PH_BWD_B      = 3'd1;
  localparam logic [PH_W-1:0] PH_BWD_T1     = 3'd2;
  localparam logic [PH_W-1:0] PH_BWD_SUM    = 3'd3;
  localparam logic [PH_W-1:0] PH_BWD_C      = 3'd4;
  localparam logic [PH_W-1:0] PH_BWD_COMMIT = 3'd6;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LOAD,
    MODE_FWD,
    MODE_LEAF,
    MODE_BWD
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [PH_W-1:0] phase;
    logic            put;
    logic            american;
  } ctl_t;

  typedef struct packed {
    logic [FAC_W-1:0] up;
    logic [FAC_W-1:0] down;
    logic [FAC_W-1:0] q;
    logic [FAC_W-1:0] qc;
    logic [FAC_W-1:0] disc;
  } fac_t;

  function automatic logic [VAL_W-1:0] payoff(input logic [VAL_W-1:0] price,
                                               input logic [VAL_W-1:0] strike,
                                               input logic put);
    logic [VAL_W-1:0] r;
    r = '0;
    if (put) begin
      if (strike > price) r = strike - price;
    end else begin
      if (price > strike) r = price - strike;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bop_if.sv
// Channel interfaces of the option pricer: request, result and register write.
interface bop_req_if;
  logic                        valid;
  logic                        ready;
  logic [bop_pkg::VAL_W-1:0]   spot_price;
  logic [bop_pkg::VAL_W-1:0]   strike_price;
  logic                        is_put;
  logic                        early_exercise;
  modport source (output valid, spot_price, strike_price, is_put, early_exercise, input ready);
  modport sink   (input valid, spot_price, strike_price, is_put, early_exercise, output ready);
endinterface

interface bop_res_if;
  logic                      valid;
  logic                      ready;
  logic [bop_pkg::VAL_W-1:0] root_price;
  modport source (output valid, root_price, input ready);
  modport sink   (input valid, root_price, output ready);
endinterface

interface bop_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bop_pkg::CFG_IDX_W-1:0] index;
  logic [bop_pkg::FAC_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bop_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module bop_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hw/rtl/bop_fxmul.sv
// Two-stage fixed-point multiplier: 48-bit value times 32-bit factor, round, saturate.
module bop_fxmul (
  input  logic                        clk_i,
  input  logic [bop_pkg::VAL_W-1:0]   a_i,
  input  logic [bop_pkg::FAC_W-1:0]   f_i,
  input  logic                        frac31_i,
  output logic [bop_pkg::VAL_W-1:0]   res_o
);
  logic [55:0]               lo_q, hi_q;
  logic                      f31_q;
  logic [80:0]               sum;
  logic [50:0]               shr;
  logic [bop_pkg::VAL_W-1:0] res_q;

  // Stage one: two 24 x 32 partial products.
  always_ff @(posedge clk_i) begin
    lo_q  <= 56'(a_i[23:0]) * 56'(f_i);
    hi_q  <= 56'(a_i[47:24]) * 56'(f_i);
    f31_q <= frac31_i;
  end

  // Stage two: merge, round half up, drop fraction, saturate.
  always_comb begin
    sum = {1'b0, hi_q, 24'b0} + 81'(lo_q) + (f31_q ? (81'(1) << 30) : (81'(1) << 29));
    shr = f31_q ? 51'(sum >> 31) : 51'(sum >> 30);
  end

  always_ff @(posedge clk_i) begin
    res_q <= (shr[50:48] != 3'b0) ? {bop_pkg::VAL_W{1'b1}} : shr[47:0];
  end

  assign res_o = res_q;
endmodule

FILE: hw/rtl/bop_cell.sv
// Lattice cell: holds one node column's price and value and its stored price history.
module bop_cell #(
  parameter int MAX_STEPS = bop_pkg::MAX_STEPS_DEF,
  parameter int IDX       = 0,
  parameter int LW        = $clog2(MAX_STEPS + 1)
) (
  input  logic                      clk_i,
  input  bop_pkg::ctl_t             ctl_i,
  input  logic [LW-1:0]             level_i,
  input  bop_pkg::fac_t             fac_i,
  input  logic [bop_pkg::VAL_W-1:0] spot_i,
  input  logic [bop_pkg::VAL_W-1:0] strike_i,
  input  logic [bop_pkg::VAL_W-1:0] left_p_i,
  input  logic [bop_pkg::VAL_W-1:0] right_v_i,
  output logic [bop_pkg::VAL_W-1:0] p_o,
  output logic [bop_pkg::VAL_W-1:0] v_o
);
  logic [bop_pkg::VAL_W-1:0] p_q, v_q, t1_q, e_q, pay_q;
  logic [bop_pkg::VAL_W-1:0] mul_a, mul_res, ram_rd, ram_wd;
  logic [bop_pkg::FAC_W-1:0] mul_f;
  logic                      mul_f31;
  logic                      own, fwd_en, fwd_wr, ram_we;
  logic [LW-1:0]             ram_wa;
  logic [bop_pkg::VAL_W:0]   esum;

  assign own    = LW'(IDX) <= level_i;
  assign fwd_en = (LW+1)'(IDX) <= ((LW+1)'(level_i) + (LW+1)'(1));
  assign fwd_wr = (ctl_i.mode == bop_pkg::MODE_FWD) && (ctl_i.phase == bop_pkg::PH_FWD_COMMIT)
                  && fwd_en;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a   = v_q;
    mul_f   = fac_i.q;
    mul_f31 = 1'b1;
    if (ctl_i.mode == bop_pkg::MODE_FWD) begin
      mul_f31 = 1'b0;
      mul_a   = own ? p_q : left_p_i;
      mul_f   = own ? fac_i.up : fac_i.down;
    end else begin
      case (ctl_i.phase)
        bop_pkg::PH_BWD_B: begin
          mul_a = right_v_i;
          mul_f = fac_i.qc;
        end
        bop_pkg::PH_BWD_C: begin
          mul_a = e_q;
          mul_f = fac_i.disc;
        end
        default: ;
      endcase
    end
  end

  bop_fxmul u_mul (
    .clk_i    (clk_i),
    .a_i      (mul_a),
    .f_i      (mul_f),
    .frac31_i (mul_f31),
    .res_o    (mul_res)
  );

  assign ram_we = (ctl_i.mode == bop_pkg::MODE_LOAD) || fwd_wr;
  assign ram_wa = (ctl_i.mode == bop_pkg::MODE_LOAD) ? '0 : level_i + LW'(1);
  assign ram_wd = (ctl_i.mode == bop_pkg::MODE_LOAD) ? spot_i : mul_res;

  bop_ram #(
    .WIDTH (bop_pkg::VAL_W),
    .DEPTH (MAX_STEPS + 1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (level_i),
    .rdata_o (ram_rd)
  );

  assign esum = {1'b0, t1_q} + {1'b0, mul_res};

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.mode)
      bop_pkg::MODE_LOAD: p_q <= spot_i;
      bop_pkg::MODE_FWD: begin
        if (fwd_wr) p_q <= mul_res;
      end
      bop_pkg::MODE_LEAF: v_q <= bop_pkg::payoff(p_q, strike_i, ctl_i.put);
      bop_pkg::MODE_BWD: begin
        case (ctl_i.phase)
          bop_pkg::PH_BWD_B:   pay_q <= bop_pkg::payoff(ram_rd, strike_i, ctl_i.put);
          bop_pkg::PH_BWD_T1:  t1_q  <= mul_res;
          bop_pkg::PH_BWD_SUM: e_q   <= esum[bop_pkg::VAL_W] ? {bop_pkg::VAL_W{1'b1}}
                                                            : esum[bop_pkg::VAL_W-1:0];
          bop_pkg::PH_BWD_COMMIT: begin
            if (own) v_q <= (ctl_i.american && (pay_q > mul_res)) ? pay_q : mul_res;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign p_o = p_q;
  assign v_o = v_q;
endmodule

FILE: hw/rtl/binomial_option_pricer_unit.sv
// Top level of the binomial option pricer: registers, sequencer and the row of lattice cells.
//
//   channel | dir | payload                                             | transfer when
//   req_i   | in  | spot_price, strike_price, is_put, early_exercise    | valid && ready
//   res_o   | out | root_price                                          | valid && ready
//   cfg_i   | in  | index, data                                         | valid && ready
//
// Once a request transfers, the sequencer steps through a load state, the forward phases
// of each of n levels (n the clamped step count), a leaf state, the backward phases of
// each level and a done state that hands the root to the output register. The next
// request is taken in the idle state after that, so requests are priced one at a time.
// The two-stage multiplier inside each cell sets the phases of each level. Reset clears
// control and registers only; the lattice stores need none.
// A new request is taken while the previous result waits in the output register; the
// sequencer holds in its last state while that register is still full.
`include "assert_macros.svh"

module binomial_option_pricer_unit #(
  parameter int MAX_STEPS = bop_pkg::MAX_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bop_req_if.sink   req_i,
  bop_res_if.source res_o,
  bop_cfg_if.sink   cfg_i
);
  localparam int LW = $clog2(MAX_STEPS + 1);
  localparam int SW = (LW > bop_pkg::STEP_W) ? LW : bop_pkg::STEP_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_FWD  = 3'd2;
  localparam logic [2:0] ST_LEAF = 3'd3;
  localparam logic [2:0] ST_BWD  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // Configuration registers.
  logic [bop_pkg::FAC_W-1:0]  up_q, down_q, prob_q, disc_q;
  logic [bop_pkg::STEP_W-1:0] steps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= bop_pkg::RST_UP_FACTOR;
      down_q  <= bop_pkg::RST_DOWN_FACTOR;
      prob_q  <= bop_pkg::RST_UP_PROB;
      disc_q  <= bop_pkg::RST_STEP_DISCOUNT;
      steps_q <= bop_pkg::RST_STEP_COUNT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bop_pkg::REG_UP_FACTOR:     up_q    <= cfg_i.data;
        bop_pkg::REG_DOWN_FACTOR:   down_q  <= cfg_i.data;
        bop_pkg::REG_UP_PROB:       prob_q  <= cfg_i.data;
        bop_pkg::REG_STEP_DISCOUNT: disc_q  <= cfg_i.data;
        bop_pkg::REG_STEP_COUNT:    steps_q <= cfg_i.data[bop_pkg::STEP_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Clamp probability and discount to one.
  bop_pkg::fac_t fac;
  always_comb begin
    fac.up   = up_q;
    fac.down = down_q;
    fac.q    = (prob_q > bop_pkg::ONE_Q31) ? bop_pkg::ONE_Q31 : prob_q;
    fac.qc   = bop_pkg::ONE_Q31 - fac.q;
    fac.disc = (disc_q > bop_pkg::ONE_Q31) ? bop_pkg::ONE_Q31 : disc_q;
  end

  // Clamp the step count to one .. MAX_STEPS.
  logic [SW-1:0] steps_ext;
  logic [LW-1:0] n_sel;
  assign steps_ext = SW'(steps_q);
  always_comb begin
    if (steps_ext == '0) n_sel = LW'(1);
    else if (steps_ext > SW'(MAX_STEPS)) n_sel = LW'(MAX_STEPS);
    else n_sel = steps_ext[LW-1:0];
  end

  // Sequencer.
  logic [2:0]                state_q, state_d;
  logic [bop_pkg::PH_W-1:0]  phase_q, phase_d;
  logic [LW-1:0]             level_q, level_d, n_q;
  logic [bop_pkg::VAL_W-1:0] spot_q, strike_q, out_val_q;
  logic                      put_q, am_q, out_vld_q, out_vld_d, req_acc, out_load;
  bop_pkg::ctl_t             ctl;
  logic [bop_pkg::VAL_W-1:0] root_v;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign out_load    = (state_q == ST_DONE) && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    level_d = level_q;
    unique case (state_q)
      ST_IDLE: if (req_acc) state_d = ST_LOAD;
      ST_LOAD: begin
        state_d = ST_FWD;
        phase_d = '0;
        level_d = '0;
      end
      ST_FWD: begin
        if (phase_q == bop_pkg::PH_FWD_COMMIT) begin
          phase_d = '0;
          if (level_q == n_q - LW'(1)) state_d = ST_LEAF;
          else level_d = level_q + LW'(1);
        end else begin
          phase_d = phase_q + bop_pkg::PH_W'(1);
        end
      end
      ST_LEAF: begin
        state_d = ST_BWD;
        phase_d = '0;
        level_d = n_q - LW'(1);
      end
      ST_BWD: begin
        if (phase_q == bop_pkg::PH_BWD_COMMIT) begin
          phase_d = '0;
          if (level_q == '0) state_d = ST_DONE;
          else level_d = level_q - LW'(1);
        end else begin
          phase_d = phase_q + bop_pkg::PH_W'(1);
        end
      end
      ST_DONE: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      level_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      level_q <= level_d;
    end
  end

  // Hold the request fields for the whole lattice run.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      spot_q   <= req_i.spot_price;
      strike_q <= req_i.strike_price;
      put_q    <= req_i.is_put;
      am_q     <= req_i.early_exercise;
      n_q      <= n_sel;
    end
  end

  // Broadcast control to the cells.
  always_comb begin
    ctl.phase    = phase_q;
    ctl.put      = put_q;
    ctl.american = am_q;
    unique case (state_q)
      ST_LOAD: ctl.mode = bop_pkg::MODE_LOAD;
      ST_FWD:  ctl.mode = bop_pkg::MODE_FWD;
      ST_LEAF: ctl.mode = bop_pkg::MODE_LEAF;
      ST_BWD:  ctl.mode = bop_pkg::MODE_BWD;
      default: ctl.mode = bop_pkg::MODE_IDLE;
    endcase
  end

  // Row of cells: prices move right in the forward pass, values move left backward.
  logic [bop_pkg::VAL_W-1:0] p_w [MAX_STEPS+1];
  logic [bop_pkg::VAL_W-1:0] v_w [MAX_STEPS+1];
  logic [bop_pkg::VAL_W-1:0] left_w [MAX_STEPS+1];
  logic [bop_pkg::VAL_W-1:0] right_w [MAX_STEPS+1];

  for (genvar gi = 0; gi <= MAX_STEPS; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign left_w[gi] = '0;
    end else begin : g_left
      assign left_w[gi] = p_w[gi-1];
    end
    if (gi == MAX_STEPS) begin : g_last
      assign right_w[gi] = '0;
    end else begin : g_right
      assign right_w[gi] = v_w[gi+1];
    end

    bop_cell #(
      .MAX_STEPS (MAX_STEPS),
      .IDX       (gi),
      .LW        (LW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .level_i   (level_q),
      .fac_i     (fac),
      .spot_i    (spot_q),
      .strike_i  (strike_q),
      .left_p_i  (left_w[gi]),
      .right_v_i (right_w[gi]),
      .p_o       (p_w[gi]),
      .v_o       (v_w[gi])
    );
  end

  assign root_v = v_w[0];

  // Output register: the root value waits here until the sink takes it.
  always_comb begin
    out_vld_d = out_vld_q && !res_o.ready;
    if (out_load) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else out_vld_q <= out_vld_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_val_q <= root_v;
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.root_price = out_val_q;

  `BOP_ASSERT(a_accept_loads, req_acc |=> (state_q == ST_LOAD), "accepted request did not load")
  `BOP_NEVER(a_bwd_phase, (state_q == ST_BWD) && (phase_q > bop_pkg::PH_BWD_COMMIT),
             "backward phase out of range")
  `BOP_ASSERT(a_done_fills, ((state_q == ST_DONE) && !out_vld_q) |=> out_vld_q,
              "finished result not moved to output register")
endmodule

FILE: sim/tb_binomial_option_pricer_unit.sv
// Testbench of the binomial option pricer: directed table, random requests, lattice predictor.
module tb_binomial_option_pricer_unit;
  import bop_pkg::*;

  typedef logic [VAL_W-1:0] val_t;

  localparam val_t VAL_TOP      = {VAL_W{1'b1}};
  localparam int   WDOG_LIMIT   = 40000;
  localparam int   HOLD_CYCLES  = 3000;
  localparam int   TAIL_CYCLES  = 2600;
  localparam int   SHOW_ERRS    = 10;

  // One row of the directed table; ref_known marks a value read off by hand.
  typedef struct {
    val_t spot;
    val_t strike;
    logic put;
    logic american;
    logic ref_known;
    val_t ref_val;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bop_req_if req ();
  bop_res_if res ();
  bop_cfg_if cfg ();

  binomial_option_pricer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // Shadow copy of the pricing registers.
  logic [FAC_W-1:0]  up_fac;
  logic [FAC_W-1:0]  dn_fac;
  logic [FAC_W-1:0]  up_prob;
  logic [FAC_W-1:0]  disc_fac;
  logic [STEP_W-1:0] n_steps;

  // Full price triangle: lat_px[level][index].
  val_t lat_px [0:MAX_STEPS_DEF][0:MAX_STEPS_DEF];
  val_t row_val [0:MAX_STEPS_DEF];

  val_t price_q [$];
  int   err_cnt;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_reqs;
  int   idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Product of a Q24.24 value and a factor with frac fraction bits, rounded half up,
  // saturated to 48 bits.
  function automatic val_t scale_val(val_t a, logic [FAC_W-1:0] f, int frac);
    logic [95:0] p;
    p = ({48'd0, a} * {64'd0, f} + (96'd1 << (frac - 1))) >> frac;
    return (p > {48'd0, VAL_TOP}) ? VAL_TOP : p[VAL_W-1:0];
  endfunction

  function automatic val_t exercise_gain(val_t px, val_t k, logic put);
    if (put) return (k > px) ? k - px : '0;
    return (px > k) ? px - k : '0;
  endfunction

  // Root value of the lattice under the shadow registers.
  function automatic val_t price_option(val_t spot, val_t k, logic put, logic american);
    int               n;
    logic [FAC_W-1:0] q;
    logic [FAC_W-1:0] qc;
    logic [FAC_W-1:0] d;
    logic [VAL_W:0]   e;
    val_t             w;
    val_t             g;
    n  = int'(n_steps);
    if (n < 1) n = 1;
    if (n > MAX_STEPS_DEF) n = MAX_STEPS_DEF;
    q  = (up_prob > ONE_Q31) ? ONE_Q31 : up_prob;
    qc = ONE_Q31 - q;
    d  = (disc_fac > ONE_Q31) ? ONE_Q31 : disc_fac;
    // Grow the triangle: up moves keep the index, the last node takes a down move.
    lat_px[0][0] = spot;
    for (int lv = 0; lv < n; lv++) begin
      for (int j = 0; j <= lv; j++) lat_px[lv+1][j] = scale_val(lat_px[lv][j], up_fac, 30);
      lat_px[lv+1][lv+1] = scale_val(lat_px[lv][lv], dn_fac, 30);
    end
    for (int j = 0; j <= n; j++) row_val[j] = exercise_gain(lat_px[n][j], k, put);
    // Roll back to the root.
    for (int lv = n - 1; lv >= 0; lv--) begin
      for (int j = 0; j <= lv; j++) begin
        e = {1'b0, scale_val(row_val[j], q, 31)} + {1'b0, scale_val(row_val[j+1], qc, 31)};
        w = scale_val(e[VAL_W] ? VAL_TOP : e[VAL_W-1:0], d, 31);
        if (american) begin
          g = exercise_gain(lat_px[lv][j], k, put);
          if (g > w) w = g;
        end
        row_val[j] = w;
      end
    end
    return row_val[0];
  endfunction

  function automatic val_t rand_val();
    return val_t'({$urandom(), $urandom()});
  endfunction

  // Write one register; call at a falling edge, returns at a falling edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FAC_W-1:0] data);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_UP_FACTOR:     up_fac   = data;
      REG_DOWN_FACTOR:   dn_fac   = data;
      REG_UP_PROB:       up_prob  = data;
      REG_STEP_DISCOUNT: disc_fac = data;
      REG_STEP_COUNT:    n_steps  = data[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // Hold until the block has drained, then load a full lattice setting.
  task automatic set_lattice(logic [FAC_W-1:0] u, logic [FAC_W-1:0] dn,
                             logic [FAC_W-1:0] q, logic [FAC_W-1:0] d, int steps);
    while (price_q.size() != 0) @(negedge clk_i);
    write_reg(REG_UP_FACTOR, u);
    write_reg(REG_DOWN_FACTOR, dn);
    write_reg(REG_UP_PROB, q);
    write_reg(REG_STEP_DISCOUNT, d);
    write_reg(REG_STEP_COUNT, steps);
  endtask

  // Offer one request, with a random idle gap first; returns at a falling edge.
  task automatic send_req(val_t spot, val_t k, logic put, logic american,
                          logic ref_known, val_t ref_val);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid          = 1'b1;
    req.spot_price     = spot;
    req.strike_price   = k;
    req.is_put         = put;
    req.early_exercise = american;
    do @(posedge clk_i); while (!req.ready);
    price_q.push_back(ref_known ? ref_val : price_option(spot, k, put, american));
    @(negedge clk_i);
  endtask

  // Random request: half the time a strike near the spot so both payoffs are live.
  task automatic send_random();
    val_t s;
    val_t k;
    val_t off;
    case ($urandom_range(3))
      0: begin
        s = rand_val();
        k = rand_val();
      end
      1, 2: begin
        s   = {16'd0, $urandom()} << $urandom_range(16);
        off = s >> $urandom_range(2, 6);
        k   = $urandom_range(1) ? s + off : s - off;
      end
      default: begin
        s = $urandom_range(1) ? VAL_TOP : val_t'($urandom_range(3));
        k = $urandom_range(1) ? VAL_TOP : val_t'($urandom_range(3));
      end
    endcase
    send_req(s, k, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
  endtask

  task automatic run_items(int cnt);
    repeat (cnt) send_random();
    req.valid = 1'b0;
  endtask

  // Realistic setting: factors near one, probability near one half, light discount.
  task automatic set_random_lattice(int steps);
    set_lattice(32'h4000_0000 + $urandom_range(32'h0400_0000),
                32'h4000_0000 - $urandom_range(32'h0400_0000),
                $urandom_range(32'h2000_0000, 32'h6000_0000),
                32'h8000_0000 - $urandom_range(32'h0100_0000), steps);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_cnt;
    int seen;
    hold_cnt  = 0;
    seen      = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != seen) begin
        seen     = hold_reqs;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready = 1'b0;
      end else begin
        res.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each returned price with the oldest expectation.
  always @(posedge clk_i) begin
    val_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (price_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_ERRS) $display("unexpected result root_price=%h", res.root_price);
      end else begin
        want = price_q.pop_front();
        if (res.root_price !== want) begin
          err_cnt++;
          if (err_cnt <= SHOW_ERRS)
            $display("root_price mismatch: expected %h actual %h", want, res.root_price);
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transfer.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    dir_row_t r;
    err_cnt        = 0;
    hold_reqs      = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.spot_price = '0;
    req.strike_price   = '0;
    req.is_put         = 1'b0;
    req.early_exercise = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    up_fac   = RST_UP_FACTOR;
    dn_fac   = RST_DOWN_FACTOR;
    up_prob  = RST_UP_PROB;
    disc_fac = RST_STEP_DISCOUNT;
    n_steps  = RST_STEP_COUNT;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset setting is a flat lattice at one half, no discount: even values come back
    // unchanged, and the saturated top stays at the top.
    dir_rows = '{
      '{'0, '0, 1'b0, 1'b0, 1'b1, '0},
      '{'0, '0, 1'b1, 1'b1, 1'b1, '0},
      '{VAL_TOP, '0, 1'b0, 1'b0, 1'b1, VAL_TOP},
      '{'0, VAL_TOP, 1'b1, 1'b0, 1'b1, VAL_TOP},
      '{VAL_TOP, VAL_TOP, 1'b1, 1'b1, 1'b1, '0},
      '{VAL_TOP, VAL_TOP, 1'b0, 1'b0, 1'b1, '0},
      '{48'd10 << 24, 48'd4 << 24, 1'b0, 1'b0, 1'b1, 48'd6 << 24},
      '{48'd4 << 24, 48'd10 << 24, 1'b1, 1'b1, 1'b1, 48'd6 << 24},
      '{48'd4 << 24, 48'd10 << 24, 1'b0, 1'b1, 1'b1, '0},
      '{48'd3, 48'd0, 1'b0, 1'b0, 1'b0, '0},
      '{48'd0, 48'd7, 1'b1, 1'b1, 1'b0, '0},
      '{VAL_TOP, 48'd1, 1'b0, 1'b1, 1'b0, '0},
      '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, 1'b0, 1'b0, '0},
      '{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_req(r.spot, r.strike, r.put, r.american, r.ref_known, r.ref_val);
    end
    req.valid = 1'b0;

    // Extremes: top up factor saturates prices, zero down factor, zero discount.
    set_lattice(32'hFFFF_FFFF, 32'h0000_0000, ONE_Q31, 32'h0000_0000, 1);
    run_items(6);
    // Zero steps act as one; probability and discount above one clamp to one.
    set_lattice(32'h4000_0000, 32'h2000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    run_items(6);
    set_lattice(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, ONE_Q31, 2);
    run_items(6);
    // Indexes past the register list are dropped; drain before writing.
    while (price_q.size() != 0) @(negedge clk_i);
    for (int ix = int'(REG_STEP_COUNT) + 1; ix < (1 << CFG_IDX_W); ix++)
      write_reg(CFG_IDX_W'(ix), $urandom());
    run_items(4);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 7;
    recv_idle_pct = 70;
    for (int p = 0; p < 6; p++) begin
      set_random_lattice($urandom_range(1, 16));
      run_items(50);
    end

    // Receiver idles lightly, sender heavily.
    send_idle_pct = 70;
    recv_idle_pct = 7;
    for (int p = 0; p < 6; p++) begin
      set_random_lattice($urandom_range(1, 16));
      run_items(50);
    end

    // No idling; a long receiver hold-off fills the block, then drain completely.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_random_lattice(12);
    run_items(40);
    hold_reqs++;
    run_items(60);
    while (price_q.size() != 0) @(negedge clk_i);
    run_items(100);

    // Full-depth lattices, few items: exactly the maximum and a count above it.
    set_random_lattice(MAX_STEPS_DEF);
    run_items(3);
    set_random_lattice(511);
    run_items(3);

    while (price_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && price_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
